>>> hw/rtl/cdd_pkg.sv
// shared types, constants and digit helpers of the clock display diff update block
`default_nettype none

package cdd_pkg;

    localparam int TEXT_LEN        = 8;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [7:0] ERASE_RESET = 8'd8;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_COLON = 8'h3A;

    // reciprocals for division by constants, exact over the value ranges used
    localparam logic [28:0] RECIP_MS_SEC   = 29'd274877907;
    localparam int          SHIFT_MS_SEC   = 38;
    localparam logic [22:0] RECIP_SEC_MIN  = 23'd4473925;
    localparam int          SHIFT_SEC_MIN  = 28;
    localparam logic [16:0] RECIP_MIN_HR   = 17'd69906;
    localparam int          SHIFT_MIN_HR   = 22;
    localparam logic [11:0] RECIP_HR_DAY   = 12'd2731;
    localparam int          SHIFT_HR_DAY   = 16;
    localparam logic [6:0]  RECIP_TEN      = 7'd103;
    localparam int          SHIFT_TEN      = 10;

    localparam logic [5:0] SIXTY      = 6'd60;
    localparam logic [4:0] TWENTYFOUR = 5'd24;
    localparam logic [3:0] TEN        = 4'd10;

    // tail lengths by first changed digit
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_HT   = 4'd8;
    localparam logic [3:0] LEN_HU   = 4'd7;
    localparam logic [3:0] LEN_MT   = 4'd5;
    localparam logic [3:0] LEN_MU   = 4'd4;
    localparam logic [3:0] LEN_ST   = 4'd2;
    localparam logic [3:0] LEN_SU   = 4'd1;

    // text positions
    localparam logic [2:0] POS_HT  = 3'd0;
    localparam logic [2:0] POS_HU  = 3'd1;
    localparam logic [2:0] POS_C1  = 3'd2;
    localparam logic [2:0] POS_MT  = 3'd3;
    localparam logic [2:0] POS_MU  = 3'd4;
    localparam logic [2:0] POS_C2  = 3'd5;
    localparam logic [2:0] POS_ST  = 3'd6;
    localparam logic [2:0] POS_SU  = 3'd7;

    typedef logic [3:0] digit_t;

    // digits[5] hours tens down to digits[0] seconds units
    typedef struct packed {
        logic [3:0]       len;
        digit_t [5:0]     digits;
    } cdd_item_t;

    // two decimal digits of a value below 100, tens in the upper nibble
    function automatic logic [7:0] split_tens(input logic [6:0] v);
        logic [13:0] p;
        logic [3:0]  t;
        logic [6:0]  u;
        p = 14'(v) * 14'(RECIP_TEN);
        t = p[13:SHIFT_TEN];
        u = v - 7'(t) * 7'(TEN);
        return {t, u[3:0]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/clock_display_diff_update.sv
// top level of the HH:MM:SS display diff updater
// the first character is presented once the beat has passed the digit pipe, queue and output register
// throughput: an item with a changed tail of L characters gives 2L output beats, up to 16,
//   one per cycle while m_ready is high, items play out back to back; the output beat count sets the rate
// the front takes one beat per cycle while the queue and 5-stage digit pipe have room
// reset: synchronous active low, clears control state and sets erase code to backspace
`default_nettype none

module clock_display_diff_update import cdd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_current_ms,
    input  wire logic [31:0] s_previous_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_char_code,
    output logic             m_last_of_run,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          push;
    logic          pop;
    logic          empty;
    cdd_item_t     push_item;
    cdd_item_t     head_item;
    logic [CW-1:0] level;
    logic [7:0]    erase_code_reg, erase_code_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        erase_code_next = erase_code_reg;
        if (cfg_valid && cfg_ready) begin
            erase_code_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_code_reg <= ERASE_RESET;
        end else begin
            erase_code_reg <= erase_code_next;
        end
    end

    cdd_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_current_ms  (s_current_ms),
        .s_previous_ms (s_previous_ms),
        .pop           (pop),
        .push          (push),
        .push_item     (push_item)
    );

    cdd_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (empty),
        .level     (level)
    );

    cdd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .erase_code    (erase_code_reg),
        .head_item     (head_item),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_last_of_run (m_last_of_run)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (level < CW'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_nonempty_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (head_item.len != LEN_NONE))
        else $error("queued item with no changed digit");

endmodule

`default_nettype wire

>>> hw/rtl/cdd_front.sv
// front end: accepts beats, splits both times into digits, finds the changed tail
`default_nettype none

module cdd_front import cdd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_current_ms,
    input  wire logic [31:0] s_previous_ms,
    input  wire logic        pop,
    output logic             push,
    output cdd_item_t        push_item
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          accept;
    logic          drop;
    logic [CW-1:0] credit_reg, credit_next;
    logic [4:0]    valid_reg, valid_next;
    logic [31:0]   ms_in [2];
    digit_t [5:0]  dig [2];
    logic [3:0]    len;

    assign ms_in[0] = s_current_ms;
    assign ms_in[1] = s_previous_ms;

    assign s_ready = (credit_reg < CW'(QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;

    for (genvar op = 0; op < 2; op++) begin : g_op
        logic [60:0] p1;
        logic [45:0] p2;
        logic [33:0] p3;
        logic [22:0] p4;
        logic [22:0] d3;
        logic [16:0] d4;
        logic [10:0] d5;
        logic [7:0]  hd, md, sd;

        logic [22:0] sec1_reg, sec1_next, sec2_reg, sec2_next;
        logic [16:0] min2_reg, min2_next, min3_reg, min3_next;
        logic [10:0] hr3_reg, hr3_next, hr4_reg, hr4_next;
        logic [5:0]  s3_reg, s3_next, s4_reg, s4_next, s5_reg, s5_next;
        logic [5:0]  m4_reg, m4_next, m5_reg, m5_next;
        logic [5:0]  hq4_reg, hq4_next;
        logic [4:0]  h5_reg, h5_next;

        always_comb begin
            p1        = 61'(ms_in[op]) * 61'(RECIP_MS_SEC);
            sec1_next = p1[60:SHIFT_MS_SEC];

            p2        = 46'(sec1_reg) * 46'(RECIP_SEC_MIN);
            min2_next = p2[44:SHIFT_SEC_MIN];
            sec2_next = sec1_reg;

            p3        = 34'(min2_reg) * 34'(RECIP_MIN_HR);
            hr3_next  = p3[32:SHIFT_MIN_HR];
            d3        = sec2_reg - 23'(min2_reg) * 23'(SIXTY);
            s3_next   = d3[5:0];
            min3_next = min2_reg;

            p4        = 23'(hr3_reg) * 23'(RECIP_HR_DAY);
            hq4_next  = p4[21:SHIFT_HR_DAY];
            d4        = min3_reg - 17'(hr3_reg) * 17'(SIXTY);
            m4_next   = d4[5:0];
            hr4_next  = hr3_reg;
            s4_next   = s3_reg;

            d5        = hr4_reg - 11'(hq4_reg) * 11'(TWENTYFOUR);
            h5_next   = d5[4:0];
            m5_next   = m4_reg;
            s5_next   = s4_reg;

            hd = split_tens(7'(h5_reg));
            md = split_tens(7'(m5_reg));
            sd = split_tens(7'(s5_reg));
        end

        assign dig[op] = {hd, md, sd};

        always_ff @(posedge aclk) begin
            sec1_reg <= sec1_next;
            sec2_reg <= sec2_next;
            min2_reg <= min2_next;
            min3_reg <= min3_next;
            hr3_reg  <= hr3_next;
            hr4_reg  <= hr4_next;
            s3_reg   <= s3_next;
            s4_reg   <= s4_next;
            s5_reg   <= s5_next;
            m4_reg   <= m4_next;
            m5_reg   <= m5_next;
            hq4_reg  <= hq4_next;
            h5_reg   <= h5_next;
        end
    end

    always_comb begin
        priority if (dig[0][5] != dig[1][5]) len = LEN_HT;
        else if (dig[0][4] != dig[1][4])     len = LEN_HU;
        else if (dig[0][3] != dig[1][3])     len = LEN_MT;
        else if (dig[0][2] != dig[1][2])     len = LEN_MU;
        else if (dig[0][1] != dig[1][1])     len = LEN_ST;
        else if (dig[0][0] != dig[1][0])     len = LEN_SU;
        else                                 len = LEN_NONE;
    end

    assign push      = valid_reg[4] && (len != LEN_NONE);
    assign drop      = valid_reg[4] && (len == LEN_NONE);
    assign push_item = {len, dig[0]};

    always_comb begin
        valid_next  = {valid_reg[3:0], accept};
        credit_next = credit_reg + CW'(accept) - CW'(drop) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            credit_reg <= '0;
        end else begin
            valid_reg  <= valid_next;
            credit_reg <= credit_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cdd_fifo.sv
// short queue of classified items between front and back
`default_nettype none

module cdd_fifo import cdd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              push,
    input  cdd_item_t                              push_item,
    input  wire logic                              pop,
    output cdd_item_t                              head_item,
    output logic                                   empty,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]     level
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cdd_item_t     mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head_item = mem_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign level     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cdd_back.sv
// back end: plays out erase codes and the changed text tail, one character per beat
`default_nettype none

module cdd_back import cdd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] erase_code,
    input  cdd_item_t       head_item,
    input  wire logic       empty,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_code,
    output logic            m_last_of_run
);

    cdd_item_t  item_reg, item_next;
    logic       busy_reg, busy_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;

    logic       advance;
    logic       last;
    logic [3:0] pos;
    logic [7:0] ch;
    logic [4:0] end_cnt;

    assign end_cnt = {item_reg.len, 1'b0} - 5'd1;
    assign last    = ({1'b0, cnt_reg} == end_cnt);
    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign pop     = !empty && (!busy_reg || (advance && last));
    assign pos     = cnt_reg + 4'(TEXT_LEN) - {item_reg.len[2:0], 1'b0};

    always_comb begin
        if (cnt_reg < item_reg.len) begin
            ch = erase_code;
        end else begin
            unique case (pos[2:0])
                POS_HT:  ch = ASCII_ZERO + 8'(item_reg.digits[5]);
                POS_HU:  ch = ASCII_ZERO + 8'(item_reg.digits[4]);
                POS_C1:  ch = ASCII_COLON;
                POS_MT:  ch = ASCII_ZERO + 8'(item_reg.digits[3]);
                POS_MU:  ch = ASCII_ZERO + 8'(item_reg.digits[2]);
                POS_C2:  ch = ASCII_COLON;
                POS_ST:  ch = ASCII_ZERO + 8'(item_reg.digits[1]);
                POS_SU:  ch = ASCII_ZERO + 8'(item_reg.digits[0]);
                default: ch = ASCII_COLON;
            endcase
        end
    end

    always_comb begin
        item_next    = item_reg;
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;

        if (advance) begin
            m_valid_next = 1'b1;
            char_next    = ch;
            last_next    = last;
            cnt_next     = cnt_reg + 4'd1;
            if (last) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop) begin
            item_next = head_item;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        char_reg <= char_next;
        last_reg <= last_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_char_code   = char_reg;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire
